// ===== sv/stsi_pkg.sv =====
// Shared constants, codes and control types of the sorted table core.
// No dependencies; every other file of the core but stsi_ram uses this package.
package stsi_pkg;

    localparam int CAPACITY    = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 31;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 6;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic commit;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic quick;
        logic scan_end;
    } sts_t;

endpackage

// ===== sv/stsi_req_if.sv =====
// Request channel of the sorted table core: opcode and value.
// Depends on stsi_pkg for field widths.
interface stsi_req_if;
    logic                               valid;
    logic                               ready;
    logic [stsi_pkg::OPCODE_W-1:0]      opcode;
    logic [stsi_pkg::VALUE_W-1:0]       value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== sv/stsi_rsp_if.sv =====
// Response channel of the sorted table core: status and entry count.
// Depends on stsi_pkg for field widths.
interface stsi_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [stsi_pkg::STATUS_W-1:0]      status;
    logic [stsi_pkg::COUNT_OUT_W-1:0]   entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ===== sv/sorted_table_insert_search_delete_core.sv =====
// Sorted table core: keeps an ascending table of 31-bit keys, duplicates allowed.
// Requests enter on req (opcode, value): insert, search, or delete first match.
// Each request returns one item on rsp: status and the entry count after it.
// Requests that need no table walk (table full on insert, empty on search or
// delete, unknown opcode) go from S_CHECK straight to S_EMIT. Others walk the
// table one entry per cycle through the RAM read port in S_SCAN, then pass
// S_COMMIT and S_EMIT; a search stops at the first entry that is equal or larger.
// One request is in work at a time; the next is taken once the response has
// appeared and the controller is back in S_IDLE.
// req.ready is high whenever no request is in work; a finished response waits
// in the output register, so the next request is taken while it stalls. A new
// response is held back only while the previous one has not been taken.
// Reset empties the table at once; there is no clearing pass.
// Depends on stsi_pkg, the channel interfaces, stsi_ctrl and stsi_dpath.
module sorted_table_insert_search_delete_core (
    input  logic        clk,
    input  logic        rst_n,
    stsi_req_if.sink    req,
    stsi_rsp_if.source  rsp
);

    stsi_pkg::cmd_t cmd;
    stsi_pkg::sts_t sts;

    stsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    stsi_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_opcode  (req.opcode),
        .in_value   (req.value),
        .out_status (rsp.status),
        .out_count  (rsp.entry_count)
    );

endmodule

// ===== sv/stsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module stsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/stsi_ctrl.sv =====
// Controller of the sorted table core: request sequencing and response valid.
// Depends on stsi_pkg for state, command and status types.
module stsi_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  stsi_pkg::sts_t  sts,
    output stsi_pkg::cmd_t  cmd
);

    stsi_pkg::state_t state_reg;
    stsi_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stsi_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stsi_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stsi_pkg::S_CHECK;
                end
            end
            stsi_pkg::S_CHECK:
            begin
                state_next = sts.quick ? stsi_pkg::S_EMIT : stsi_pkg::S_SCAN;
            end
            stsi_pkg::S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = stsi_pkg::S_COMMIT;
                end
            end
            stsi_pkg::S_COMMIT:
            begin
                state_next = stsi_pkg::S_EMIT;
            end
            stsi_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = stsi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = stsi_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            stsi_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            stsi_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
            end
            stsi_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            stsi_pkg::S_COMMIT:
            begin
                cmd.commit = 1'b1;
            end
            stsi_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/stsi_dpath.sv =====
// Datapath of the sorted table core: table RAM, scan pipeline, count and result.
// Depends on stsi_pkg and stsi_ram.
module stsi_dpath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stsi_pkg::cmd_t                   cmd,
    output stsi_pkg::sts_t                   sts,
    input  logic [stsi_pkg::OPCODE_W-1:0]    in_opcode,
    input  logic [stsi_pkg::VALUE_W-1:0]     in_value,
    output logic [stsi_pkg::STATUS_W-1:0]    out_status,
    output logic [stsi_pkg::COUNT_OUT_W-1:0] out_count
);

    localparam int AW = stsi_pkg::ADDR_W;
    localparam int CW = stsi_pkg::CNT_W;
    localparam int VW = stsi_pkg::VALUE_W;

    logic [stsi_pkg::OPCODE_W-1:0]    opcode_reg;
    logic [VW-1:0]                    value_reg;
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    count_next;
    logic [CW-1:0]                    k_reg;
    logic [CW-1:0]                    k_next;
    logic                             pipe_vld_reg;
    logic                             pipe_vld_next;
    logic [AW-1:0]                    pipe_k_reg;
    logic [AW-1:0]                    pipe_k_next;
    logic [VW-1:0]                    carry_reg;
    logic [VW-1:0]                    carry_next;
    logic                             hit_reg;
    logic                             hit_next;
    logic                             stop_reg;
    logic                             stop_next;
    stsi_pkg::status_t                status_reg;
    stsi_pkg::status_t                status_next;
    stsi_pkg::status_t                quick_code;
    logic [stsi_pkg::STATUS_W-1:0]    out_status_reg;
    logic [stsi_pkg::COUNT_OUT_W-1:0] out_count_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VW-1:0] ram_wdata;
    logic [VW-1:0] ram_rdata;
    logic          is_empty;
    logic          is_full;

    stsi_ram #(
        .WIDTH (VW),
        .DEPTH (stsi_pkg::CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(stsi_pkg::CAPACITY));

    always_comb
    begin
        sts.quick    = 1'b1;
        sts.scan_end = stop_reg || ((k_reg == count_reg) && !pipe_vld_reg);
        quick_code   = stsi_pkg::ST_NOT_FOUND;
        unique case (opcode_reg)
            stsi_pkg::OP_INSERT:
            begin
                sts.quick  = is_full;
                quick_code = stsi_pkg::ST_FULL;
            end
            stsi_pkg::OP_SEARCH, stsi_pkg::OP_DELETE:
            begin
                sts.quick  = is_empty;
                quick_code = stsi_pkg::ST_EMPTY;
            end
            default:
            begin
                sts.quick  = 1'b1;
                quick_code = stsi_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        count_next    = count_reg;
        k_next        = k_reg;
        pipe_vld_next = pipe_vld_reg;
        pipe_k_next   = pipe_k_reg;
        carry_next    = carry_reg;
        hit_next      = hit_reg;
        stop_next     = stop_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = pipe_k_reg;
        ram_wdata     = value_reg;

        if (cmd.check)
        begin
            k_next        = '0;
            pipe_vld_next = 1'b0;
            hit_next      = 1'b0;
            stop_next     = 1'b0;
            status_next   = sts.quick ? quick_code : stsi_pkg::ST_OK;
        end

        if (cmd.scan)
        begin
            pipe_vld_next = (k_reg < count_reg);
            pipe_k_next   = k_reg[AW-1:0];
            if (k_reg < count_reg)
            begin
                k_next = k_reg + CW'(1);
            end
            if (pipe_vld_reg && !stop_reg)
            begin
                unique case (opcode_reg)
                    stsi_pkg::OP_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = carry_reg;
                            carry_next = ram_rdata;
                        end
                        else if (ram_rdata >= value_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = value_reg;
                            carry_next = ram_rdata;
                            hit_next   = 1'b1;
                        end
                    end
                    stsi_pkg::OP_SEARCH:
                    begin
                        if (ram_rdata == value_reg)
                        begin
                            hit_next  = 1'b1;
                            stop_next = 1'b1;
                        end
                        else if (ram_rdata > value_reg)
                        begin
                            stop_next = 1'b1;
                        end
                    end
                    stsi_pkg::OP_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pipe_k_reg - AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        else if (ram_rdata == value_reg)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        hit_next = hit_reg;
                    end
                endcase
            end
        end

        if (cmd.commit)
        begin
            unique case (opcode_reg)
                stsi_pkg::OP_INSERT:
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = count_reg[AW-1:0];
                    ram_wdata   = hit_reg ? carry_reg : value_reg;
                    count_next  = count_reg + CW'(1);
                    status_next = stsi_pkg::ST_OK;
                end
                stsi_pkg::OP_DELETE:
                begin
                    if (hit_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    status_next = hit_reg ? stsi_pkg::ST_OK : stsi_pkg::ST_NOT_FOUND;
                end
                default:
                begin
                    status_next = hit_reg ? stsi_pkg::ST_OK : stsi_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            k_reg        <= '0;
            pipe_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            stop_reg     <= 1'b0;
            status_reg   <= stsi_pkg::ST_OK;
        end
        else
        begin
            count_reg    <= count_next;
            k_reg        <= k_next;
            pipe_vld_reg <= pipe_vld_next;
            hit_reg      <= hit_next;
            stop_reg     <= stop_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_k_reg <= pipe_k_next;
        carry_reg  <= carry_next;
        if (cmd.load)
        begin
            opcode_reg <= in_opcode;
            value_reg  <= in_value;
        end
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= stsi_pkg::COUNT_OUT_W'(count_reg);
        end
    end

    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule
